[hdl/mph_pkg.sv]
`default_nettype none

package mph_pkg;

	localparam int NOTE_COUNT  = 128;
	localparam int GROUP_WIDTH = 16;
	localparam int GROUP_COUNT = (NOTE_COUNT + GROUP_WIDTH - 1) / GROUP_WIDTH;
	localparam int NOTE_SPAN   = GROUP_COUNT * GROUP_WIDTH;
	localparam int NOTE_IDX_W  = $clog2(NOTE_SPAN);
	localparam int GROUP_IDX_W = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
	localparam int MAX_RESULTS = 8;
	localparam int FOUND_W     = $clog2(MAX_RESULTS + 1);
	localparam int MASK_W      = 16;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int PROD_W      = 15;
	localparam int RECIP_W     = 13;
	localparam int RECIP_SHIFT = 19;

	localparam logic [1:0] CMD_NOTE_ON  = 2'd0;
	localparam logic [1:0] CMD_NOTE_OFF = 2'd1;
	localparam logic [1:0] CMD_CTRL     = 2'd2;

	localparam logic [6:0] CC_HOLD         = 7'd64;
	localparam logic [6:0] CC_SOST         = 7'd66;
	localparam logic [6:0] CC_SOFT         = 7'd67;
	localparam logic [6:0] CC_ALL_OFF      = 7'd120;
	localparam logic [6:0] CC_MODE_FIRST   = 7'd123;
	localparam logic [6:0] PEDAL_THRESHOLD = 7'd63;
	localparam logic [6:0] VEL_MAX         = 7'd127;

	localparam logic [1:0] CFG_LISTEN_CHANNEL = 2'd0;
	localparam logic [1:0] CFG_REPLACE_MODE   = 2'd1;
	localparam logic [1:0] CFG_SOFT_ENABLE    = 2'd2;
	localparam logic [1:0] CFG_SOFT_PERCENT   = 2'd3;

	localparam logic [7:0] SOFT_PERCENT_RESET = 8'd50;

	// floor(x / 100) == (x * 5243) >> 19 for every x below 2^15
	localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;

	typedef enum logic [2:0] {
		OP_FWD,
		OP_NOTE_ON,
		OP_NOTE_OFF,
		OP_ALL_OFF,
		OP_HOLD,
		OP_SOST,
		OP_SOFT
	} op_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SCAN,
		BK_FLUSH
	} back_state_t;

	typedef struct packed {
		logic [3:0] listen_channel;
		logic       replace_mode;
		logic       soft_enable;
		logic [7:0] soft_percent;
	} cfg_t;

	typedef struct packed {
		op_t              op;
		logic             pressed;
		logic             note_ok;
		logic [1:0]       cmd;
		logic [3:0]       channel;
		logic [6:0]       data_one;
		logic [6:0]       data_two;
		logic [PROD_W-1:0] prod;
	} item_t;

	typedef struct packed {
		logic              kind;
		logic [1:0]        evt;
		logic [3:0]        channel;
		logic [6:0]        data_one;
		logic [6:0]        data_two;
		logic [2:0]        group;
		logic [MASK_W-1:0] mask;
		logic              last;
	} result_t;

endpackage

`default_nettype wire

[hdl/mph_front.sv]
`default_nettype none

module mph_front
	import mph_pkg::*;
(
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] cmd,
	input  wire logic [3:0] channel,
	input  wire logic [6:0] data_one,
	input  wire logic [6:0] data_two,
	input  wire cfg_t       cfg,
	input  wire logic       q_ready,
	output logic            push,
	output item_t           push_item
);

	logic mine;
	logic note_ok;
	logic pressed;
	op_t  op;

	assign mine    = (channel == cfg.listen_channel);
	assign note_ok = ({1'b0, data_one} < 8'(NOTE_COUNT));
	assign pressed = (data_two > PEDAL_THRESHOLD);

	always_comb begin
		op = OP_FWD;
		if (mine) begin
			unique case (cmd)
				CMD_NOTE_ON: op = OP_NOTE_ON;
				CMD_NOTE_OFF: op = note_ok ? OP_NOTE_OFF : OP_FWD;
				CMD_CTRL: begin
					if (data_one >= CC_MODE_FIRST || data_one == CC_ALL_OFF) begin
						op = OP_ALL_OFF;
					end else if (data_one == CC_HOLD) begin
						op = OP_HOLD;
					end else if (data_one == CC_SOST) begin
						op = OP_SOST;
					end else if (data_one == CC_SOFT) begin
						op = OP_SOFT;
					end
				end
				default: op = OP_FWD;
			endcase
		end
	end

	assign in_ready = q_ready;
	assign push     = in_valid & q_ready;

	always_comb begin
		push_item          = '0;
		push_item.op       = op;
		push_item.pressed  = pressed;
		push_item.note_ok  = note_ok;
		push_item.cmd      = cmd;
		push_item.channel  = channel;
		push_item.data_one = data_one;
		push_item.data_two = data_two;
		// velocity times percent; the divide by 100 happens in the back end
		push_item.prod     = PROD_W'(data_two) * PROD_W'(cfg.soft_percent);
	end

endmodule

`default_nettype wire

[hdl/mph_queue.sv]
`default_nettype none

module mph_queue
	import mph_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire item_t push_item,
	output logic       q_ready,
	input  wire logic  pop,
	output logic       q_valid,
	output item_t      q_item
);

	item_t             entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign q_ready = (cnt_q != QCNT_W'(QUEUE_DEPTH));
	assign q_valid = (cnt_q != '0);
	assign q_item  = entry_q[rd_ptr_q];
	assign do_push = push & q_ready;
	assign do_pop  = pop & q_valid;

	function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

[hdl/mph_back.sv]
`default_nettype none

module mph_back
	import mph_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cfg_t  cfg,
	input  wire logic  q_valid,
	input  wire item_t q_item,
	output logic       pop,
	input  wire logic  out_ready,
	output logic       out_valid,
	output result_t    out_res
);

	back_state_t state_q, state_d;

	logic [NOTE_SPAN-1:0] down_q;
	logic [NOTE_SPAN-1:0] damped_q;
	logic [NOTE_SPAN-1:0] sost_q;
	logic                 hold_on_q;
	logic                 sost_on_q;
	logic                 soft_on_q;

	logic [GROUP_IDX_W-1:0] grp_q;
	logic [FOUND_W-1:0]     found_q;
	logic                   scan_hold_q;
	logic                   pend_v_q;
	logic [MASK_W-1:0]      pend_mask_q;
	logic [2:0]             pend_grp_q;

	logic    out_valid_q;
	result_t out_q;

	logic [GROUP_WIDTH-1:0] down_rows   [GROUP_COUNT];
	logic [GROUP_WIDTH-1:0] damped_rows [GROUP_COUNT];
	logic [GROUP_WIDTH-1:0] sost_rows   [GROUP_COUNT];
	logic [NOTE_SPAN-1:0]   clr_vec;

	logic [GROUP_WIDTH-1:0] rel_row;
	logic [MASK_W-1:0]      mask;
	logic                   found_new;
	logic                   grp_last;
	logic                   can_load;
	logic [NOTE_IDX_W-1:0]  note_idx;
	logic                   held;
	logic                   start_scan;

	logic [PROD_W+RECIP_W-1:0] recip_prod;
	logic [8:0]                vel_quot;
	logic [6:0]                vel_out;

	logic    scan_step;
	logic    load;
	logic    pend_take;
	logic    pend_clear;
	result_t load_res;

	genvar r;
	generate
		for (r = 0; r < GROUP_COUNT; r++) begin : g_rows
			assign down_rows[r]   = down_q[r*GROUP_WIDTH +: GROUP_WIDTH];
			assign damped_rows[r] = damped_q[r*GROUP_WIDTH +: GROUP_WIDTH];
			assign sost_rows[r]   = sost_q[r*GROUP_WIDTH +: GROUP_WIDTH];
			assign clr_vec[r*GROUP_WIDTH +: GROUP_WIDTH] =
				{GROUP_WIDTH{grp_q == GROUP_IDX_W'(r)}};
		end
	endgenerate

	always_comb begin
		if (scan_hold_q) begin
			rel_row = damped_rows[grp_q] & ~down_rows[grp_q] & ~sost_rows[grp_q];
		end else begin
			rel_row = sost_rows[grp_q] & ~down_rows[grp_q] & ~damped_rows[grp_q];
		end
	end

	assign mask      = MASK_W'(rel_row);
	assign found_new = (mask != '0) && (found_q < FOUND_W'(MAX_RESULTS));
	assign grp_last  = (grp_q == GROUP_IDX_W'(GROUP_COUNT - 1));
	assign can_load  = !out_valid_q || out_ready;
	assign note_idx  = NOTE_IDX_W'(q_item.data_one);
	assign held      = damped_q[note_idx] | sost_q[note_idx];
	assign start_scan = (q_item.op == OP_HOLD || q_item.op == OP_SOST) && !q_item.pressed;

	assign recip_prod = (PROD_W+RECIP_W)'(q_item.prod) * (PROD_W+RECIP_W)'(RECIP_100);
	assign vel_quot   = recip_prod[PROD_W+RECIP_W-1:RECIP_SHIFT];
	assign vel_out    = (vel_quot > 9'(VEL_MAX)) ? VEL_MAX : vel_quot[6:0];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (q_valid && can_load && start_scan) begin
					state_d = BK_SCAN;
				end
			end
			BK_SCAN: begin
				if (scan_step && grp_last) begin
					state_d = BK_FLUSH;
				end
			end
			BK_FLUSH: begin
				if (!pend_v_q || can_load) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// control and result selection
	always_comb begin
		pop        = 1'b0;
		scan_step  = 1'b0;
		load       = 1'b0;
		pend_take  = 1'b0;
		pend_clear = 1'b0;
		load_res          = '0;
		load_res.kind     = 1'b1;
		load_res.evt      = CMD_NOTE_OFF;
		load_res.channel  = cfg.listen_channel;
		load_res.group    = pend_grp_q;
		load_res.mask     = pend_mask_q;
		unique case (state_q)
			BK_IDLE: begin
				pop = q_valid && can_load;
				case (q_item.op)
					OP_FWD, OP_ALL_OFF, OP_NOTE_ON: load = pop;
					OP_NOTE_OFF: load = pop && !held;
					default: load = 1'b0;
				endcase
				load_res          = '0;
				load_res.kind     = 1'b0;
				load_res.evt      = q_item.cmd;
				load_res.channel  = q_item.channel;
				load_res.data_one = q_item.data_one;
				load_res.data_two = q_item.data_two;
				load_res.last     = 1'b1;
				if (q_item.op == OP_NOTE_ON && cfg.soft_enable && soft_on_q) begin
					load_res.data_two = vel_out;
				end
			end
			BK_SCAN: begin
				// a new mask pushes the previous one out, which is then not the last
				scan_step = !(found_new && pend_v_q && !can_load);
				load      = scan_step && found_new && pend_v_q;
				pend_take = scan_step && found_new;
				load_res.last = 1'b0;
			end
			BK_FLUSH: begin
				load          = pend_v_q && can_load;
				pend_clear    = load;
				load_res.last = 1'b1;
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			down_q    <= '0;
			damped_q  <= '0;
			sost_q    <= '0;
			hold_on_q <= 1'b0;
			sost_on_q <= 1'b0;
			soft_on_q <= 1'b0;
		end else begin
			if (pop) begin
				case (q_item.op)
					OP_NOTE_ON: begin
						if (q_item.note_ok) begin
							down_q[note_idx] <= 1'b1;
							if (!cfg.replace_mode) begin
								damped_q[note_idx] <= hold_on_q;
							end
						end
					end
					OP_NOTE_OFF: down_q[note_idx] <= 1'b0;
					OP_ALL_OFF: begin
						down_q   <= '0;
						damped_q <= '0;
						sost_q   <= '0;
					end
					OP_HOLD: begin
						hold_on_q <= q_item.pressed;
						if (q_item.pressed) begin
							damped_q <= down_q;
						end
					end
					OP_SOST: begin
						sost_on_q <= q_item.pressed;
						if (q_item.pressed) begin
							sost_q <= down_q;
						end
					end
					OP_SOFT: soft_on_q <= q_item.pressed;
					default: ;
				endcase
			end else if (scan_step) begin
				if (scan_hold_q) begin
					damped_q <= damped_q & ~clr_vec;
				end else begin
					sost_q <= sost_q & ~clr_vec;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			grp_q       <= '0;
			found_q     <= '0;
			scan_hold_q <= 1'b0;
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pop && start_scan) begin
				grp_q       <= '0;
				found_q     <= '0;
				scan_hold_q <= (q_item.op == OP_HOLD);
			end else if (scan_step) begin
				grp_q <= grp_q + 1'b1;
				if (found_new) begin
					found_q <= found_q + 1'b1;
				end
			end
			if (pend_take) begin
				pend_v_q <= 1'b1;
			end else if (pend_clear) begin
				pend_v_q <= 1'b0;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pend_take) begin
			pend_mask_q <= mask;
			pend_grp_q  <= 3'(grp_q);
		end
		if (load) begin
			out_q <= load_res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_q;

endmodule

`default_nettype wire

[hdl/midi_pedal_hold_filter.sv]
`default_nettype none

// MIDI pedal filter for one listen channel: tracks down, sustain-damped and
// sostenuto-held flags per note, absorbs the hold, sostenuto and soft pedal
// controllers, scales note-on velocity under the soft pedal and drops
// note-offs of held notes. Events on other channels pass through. An accepted
// event goes into a two-entry queue; a forwarded event moves on to the
// output register once the back end is idle and that register is free. A
// pedal release walks the note flags one group of 16 notes per cycle while
// the output does not stall, so after it leaves the queue it holds the back
// end for the scan of all 8 groups and a flush state for the final mask,
// and emits up to 8 note-off masks, the last one flagged. While the back
// end walks the groups, the input side keeps taking events until the queue
// is full. Register writes are only expected while nothing is in flight.
module midi_pedal_hold_filter
	import mph_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_idx,
	input  wire logic [7:0]  cfg_data,

	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  cmd,
	input  wire logic [3:0]  channel,
	input  wire logic [6:0]  data_one,
	input  wire logic [6:0]  data_two,

	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             out_kind,
	output logic [1:0]       out_event,
	output logic [3:0]       out_channel,
	output logic [6:0]       out_data_one,
	output logic [6:0]       out_data_two,
	output logic [2:0]       release_group,
	output logic [15:0]      release_mask,
	output logic             last
);

	cfg_t    cfg_q;
	logic    q_ready;
	logic    push;
	item_t   push_item;
	logic    pop;
	logic    q_valid;
	item_t   q_item;
	result_t out_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.listen_channel <= '0;
			cfg_q.replace_mode   <= 1'b0;
			cfg_q.soft_enable    <= 1'b0;
			cfg_q.soft_percent   <= SOFT_PERCENT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_LISTEN_CHANNEL: cfg_q.listen_channel <= cfg_data[3:0];
				CFG_REPLACE_MODE:   cfg_q.replace_mode   <= cfg_data[0];
				CFG_SOFT_ENABLE:    cfg_q.soft_enable    <= cfg_data[0];
				CFG_SOFT_PERCENT:   cfg_q.soft_percent   <= cfg_data;
				default: ;
			endcase
		end
	end

	mph_front u_front (
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.channel   (channel),
		.data_one  (data_one),
		.data_two  (data_two),
		.cfg       (cfg_q),
		.q_ready   (q_ready),
		.push      (push),
		.push_item (push_item)
	);

	mph_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.q_ready   (q_ready),
		.pop       (pop),
		.q_valid   (q_valid),
		.q_item    (q_item)
	);

	mph_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.pop       (pop),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_res   (out_res)
	);

	assign out_kind      = out_res.kind;
	assign out_event     = out_res.evt;
	assign out_channel   = out_res.channel;
	assign out_data_one  = out_res.data_one;
	assign out_data_two  = out_res.data_two;
	assign release_group = out_res.group;
	assign release_mask  = out_res.mask;
	assign last          = out_res.last;

endmodule

`default_nettype wire

[hdl/mph_checker.sv]
`default_nettype none

module mph_checker
	import mph_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic        out_kind,
	input wire logic [1:0]  out_event,
	input wire logic [3:0]  out_channel,
	input wire logic [6:0]  out_data_one,
	input wire logic [6:0]  out_data_two,
	input wire logic [2:0]  release_group,
	input wire logic [15:0] release_mask,
	input wire logic        last
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(release_mask) && $stable(last)
			&& $stable(out_data_two) && $stable(out_kind) && $stable(out_event)
			&& $stable(out_channel) && $stable(out_data_one) && $stable(release_group))
	else $error("result changed while stalled");

	// release masks are never empty and carry a bare note-off
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind |-> release_mask != '0 && out_event == CMD_NOTE_OFF
			&& out_data_one == '0 && out_data_two == '0)
	else $error("malformed release mask");

	// a forwarded event is always the only result of its request
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_kind |-> last && release_group == '0 && release_mask == '0)
	else $error("malformed forwarded event");

	// nothing is presented right after reset
	assert property (@(posedge clk) $rose(arst_n) |-> !out_valid)
	else $error("result valid out of reset");

endmodule

bind midi_pedal_hold_filter mph_checker u_mph_checker (.*);

`default_nettype wire

[tb/sv/tb_top.sv]
`default_nettype none

module tb_top;
	import mph_pkg::*;

	localparam logic [1:0] CMD_OTHER = 2'd3;
	// up to three silent releases in flight, each scanning every group; leave margin
	localparam int SETTLE_CYCLES = 40;
	localparam int PHASE_EVENTS  = 50;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;

	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_idx = CFG_LISTEN_CHANNEL;
	logic [7:0]  cfg_data = '0;

	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  cmd = CMD_NOTE_ON;
	logic [3:0]  channel = '0;
	logic [6:0]  data_one = '0;
	logic [6:0]  data_two = '0;

	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        out_kind;
	logic [1:0]  out_event;
	logic [3:0]  out_channel;
	logic [6:0]  out_data_one;
	logic [6:0]  out_data_two;
	logic [2:0]  release_group;
	logic [15:0] release_mask;
	logic        last;

	result_t pending_outputs[$];
	int      errors = 0;
	int      events_sent = 0;
	int      send_gap_pct = 22;
	int      recv_stall_pct = 83;

	// predictor copy of configuration and pedal/note state
	logic [3:0]            cur_channel = '0;
	logic                  cur_replace = 1'b0;
	logic                  cur_soft_en = 1'b0;
	logic [7:0]            cur_soft_pct = SOFT_PERCENT_RESET;
	logic [NOTE_COUNT-1:0] keys_down = '0;
	logic [NOTE_COUNT-1:0] keys_sustained = '0;
	logic [NOTE_COUNT-1:0] keys_sostenuto = '0;
	logic                  hold_pedal = 1'b0;
	logic                  sost_pedal = 1'b0;
	logic                  soft_pedal = 1'b0;

	midi_pedal_hold_filter u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.channel(channel),
		.data_one(data_one),
		.data_two(data_two),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_kind(out_kind),
		.out_event(out_event),
		.out_channel(out_channel),
		.out_data_one(out_data_one),
		.out_data_two(out_data_two),
		.release_group(release_group),
		.release_mask(release_mask),
		.last(last)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	initial begin
		#2000000;
		$display("tb_top NOT OK");
		$finish;
	end

	task automatic predict_midi_outputs(input logic [1:0] c, input logic [3:0] ch,
			input logic [6:0] d1, input logic [6:0] d2);
		result_t               outs[MAX_RESULTS];
		result_t               r;
		logic [NOTE_COUNT-1:0] freed;
		logic                  pressed;
		logic                  forward;
		logic [6:0]            vel;
		int                    scaled;
		int                    n;
		int                    g;
		forward = 1'b1;
		freed = '0;
		vel = d2;
		n = 0;
		pressed = (d2 > PEDAL_THRESHOLD);
		if (ch == cur_channel) begin
			case (c)
				CMD_NOTE_ON: begin
					keys_down[d1] = 1'b1;
					if (!cur_replace)
						keys_sustained[d1] = hold_pedal;
					if (cur_soft_en && soft_pedal) begin
						scaled = int'(d2) * int'(cur_soft_pct) / 100;
						vel = (scaled > int'(VEL_MAX)) ? VEL_MAX : 7'(scaled);
					end
				end
				CMD_NOTE_OFF: begin
					keys_down[d1] = 1'b0;
					if (keys_sustained[d1] || keys_sostenuto[d1])
						forward = 1'b0;
				end
				CMD_CTRL: begin
					if (d1 >= CC_MODE_FIRST || d1 == CC_ALL_OFF) begin
						keys_down = '0;
						keys_sustained = '0;
						keys_sostenuto = '0;
					end else if (d1 == CC_HOLD) begin
						forward = 1'b0;
						hold_pedal = pressed;
						if (pressed) begin
							keys_sustained = keys_down;
						end else begin
							freed = keys_sustained & ~keys_down & ~keys_sostenuto;
							keys_sustained = '0;
						end
					end else if (d1 == CC_SOST) begin
						forward = 1'b0;
						sost_pedal = pressed;
						if (pressed) begin
							keys_sostenuto = keys_down;
						end else begin
							freed = keys_sostenuto & ~keys_down & ~keys_sustained;
							keys_sostenuto = '0;
						end
					end else if (d1 == CC_SOFT) begin
						forward = 1'b0;
						soft_pedal = pressed;
					end
				end
				default: ;
			endcase
		end

		for (g = 0; g < GROUP_COUNT; g++) begin
			if (freed[g*MASK_W +: MASK_W] != '0 && n < MAX_RESULTS) begin
				r = '0;
				r.kind = 1'b1;
				r.evt = CMD_NOTE_OFF;
				r.channel = cur_channel;
				r.group = 3'(g);
				r.mask = freed[g*MASK_W +: MASK_W];
				outs[n] = r;
				n++;
			end
		end
		if (forward) begin
			r = '0;
			r.evt = c;
			r.channel = ch;
			r.data_one = d1;
			r.data_two = vel;
			outs[n] = r;
			n++;
		end
		if (n > 0)
			outs[n-1].last = 1'b1;
		for (g = 0; g < n; g++)
			pending_outputs.push_back(outs[g]);
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : check_outputs
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_outputs.size() == 0) begin
				errors++;
				$write("%0t: output with none expected, got kind=%0d event=%0d ch=%0d",
					$time, out_kind, out_event, out_channel);
				$display(" d1=%0d d2=%0d grp=%0d mask=%h last=%0d",
					out_data_one, out_data_two, release_group, release_mask, last);
			end else begin
				want = pending_outputs.pop_front();
				check_field("out_kind", 16'(want.kind), 16'(out_kind));
				check_field("out_event", 16'(want.evt), 16'(out_event));
				check_field("out_channel", 16'(want.channel), 16'(out_channel));
				check_field("out_data_one", 16'(want.data_one), 16'(out_data_one));
				check_field("out_data_two", 16'(want.data_two), 16'(out_data_two));
				check_field("release_group", 16'(want.group), 16'(release_group));
				check_field("release_mask", want.mask, release_mask);
				check_field("last", 16'(want.last), 16'(last));
			end
		end
	end

	// called at a falling edge, returns at a falling edge
	task automatic send_event(input logic [1:0] c, input logic [3:0] ch,
			input logic [6:0] d1, input logic [6:0] d2);
		if ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			do
				@(negedge clk);
			while ($urandom_range(99) < send_gap_pct);
		end
		in_valid <= 1'b1;
		cmd <= c;
		channel <= ch;
		data_one <= d1;
		data_two <= d2;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_midi_outputs(c, ch, d1, d2);
		events_sent++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_outputs.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= value;
		@(negedge clk);
	endtask

	task automatic set_config(input logic [3:0] ch, input logic rep, input logic soft_en,
			input logic [7:0] pct);
		wait_drained();
		write_reg(CFG_LISTEN_CHANNEL, {4'b0, ch});
		write_reg(CFG_REPLACE_MODE, {7'b0, rep});
		write_reg(CFG_SOFT_ENABLE, {7'b0, soft_en});
		write_reg(CFG_SOFT_PERCENT, pct);
		cfg_we <= 1'b0;
		cur_channel = ch;
		cur_replace = rep;
		cur_soft_en = soft_en;
		cur_soft_pct = pct;
	endtask

	task automatic test_basic_events();
		send_event(CMD_NOTE_ON, 4'd0, 7'd0, 7'd127);
		send_event(CMD_NOTE_ON, 4'd0, 7'd127, 7'd0);
		send_event(CMD_CTRL, 4'd0, CC_HOLD, 7'd64);       // just above threshold
		send_event(CMD_NOTE_OFF, 4'd0, 7'd0, 7'd64);      // damped, dropped
		send_event(CMD_NOTE_ON, 4'd5, 7'd60, 7'd100);     // foreign channel
		send_event(CMD_OTHER, 4'd0, 7'd127, 7'd127);
		send_event(CMD_CTRL, 4'd0, CC_SOST, 7'd127);
		send_event(CMD_NOTE_OFF, 4'd0, 7'd127, 7'd0);     // sostenuto-held, dropped
		send_event(CMD_CTRL, 4'd0, CC_HOLD, PEDAL_THRESHOLD);
		send_event(CMD_CTRL, 4'd0, CC_SOST, 7'd0);
		send_event(CMD_CTRL, 4'd0, CC_SOFT, 7'd127);
		send_event(CMD_NOTE_ON, 4'd0, 7'd64, 7'd100);     // soft not enabled
		send_event(CMD_CTRL, 4'd0, 7'd7, 7'd5);
		send_event(CMD_CTRL, 4'd0, CC_ALL_OFF, 7'd0);
		send_event(CMD_CTRL, 4'd0, CC_MODE_FIRST, 7'd0);
		send_event(CMD_CTRL, 4'd0, 7'd127, 7'd127);
		send_event(CMD_CTRL, 4'd15, CC_HOLD, 7'd127);     // pedal on other channel passes
		send_event(CMD_CTRL, 4'd0, CC_SOFT, 7'd0);
	endtask

	// one held note in each group, so a hold release yields every mask
	task automatic test_all_groups();
		int g;
		send_event(CMD_CTRL, cur_channel, CC_HOLD, 7'd100);
		for (g = 0; g < GROUP_COUNT; g++)
			send_event(CMD_NOTE_ON, cur_channel, 7'(g*MASK_W + MASK_W - 1 - g), 7'(g + 1));
		for (g = 0; g < GROUP_COUNT; g++)
			send_event(CMD_NOTE_OFF, cur_channel, 7'(g*MASK_W + MASK_W - 1 - g), 7'd0);
		send_event(CMD_CTRL, cur_channel, CC_HOLD, 7'd0);
	endtask

	task automatic test_soft_and_replace();
		set_config(4'd15, 1'b1, 1'b1, 8'd255);
		send_event(CMD_CTRL, 4'd15, CC_SOFT, 7'd127);
		send_event(CMD_NOTE_ON, 4'd15, 7'd20, 7'd127);    // saturates
		send_event(CMD_NOTE_ON, 4'd15, 7'd21, 7'd1);
		send_event(CMD_CTRL, 4'd15, CC_HOLD, 7'd127);
		send_event(CMD_NOTE_ON, 4'd15, 7'd22, 7'd50);     // replace: no damp latch
		send_event(CMD_NOTE_OFF, 4'd15, 7'd22, 7'd50);
		send_event(CMD_NOTE_OFF, 4'd15, 7'd20, 7'd0);
		send_event(CMD_CTRL, 4'd15, CC_HOLD, 7'd0);
		set_config(4'd0, 1'b0, 1'b1, 8'd0);
		send_event(CMD_NOTE_ON, 4'd0, 7'd30, 7'd127);
		set_config(4'd7, 1'b0, 1'b1, 8'd100);
		send_event(CMD_NOTE_ON, 4'd7, 7'd31, 7'd99);
		send_event(CMD_CTRL, 4'd7, CC_ALL_OFF, 7'd0);
	endtask

	task automatic press_or_release(input logic [6:0] pedal, input logic press);
		send_event(CMD_CTRL, cur_channel, pedal,
			press ? 7'($urandom_range(127, 64)) : 7'($urandom_range(63, 0)));
	endtask

	// a well-formed phrase: notes under hold and/or sostenuto, then releases
	task automatic play_phrase();
		logic [6:0] notes[6];
		int         k;
		int         i;
		logic       use_hold;
		logic       use_sost;
		k = $urandom_range(6, 1);
		use_hold = 1'($urandom_range(1, 0));
		use_sost = 1'($urandom_range(1, 0));
		for (i = 0; i < k; i++)
			notes[i] = 7'($urandom_range(127, 0));
		if (use_hold)
			press_or_release(CC_HOLD, 1'b1);
		for (i = 0; i < k; i++)
			send_event(CMD_NOTE_ON, cur_channel, notes[i], 7'($urandom_range(127, 0)));
		if ($urandom_range(3, 0) == 0)
			press_or_release(CC_SOFT, 1'($urandom_range(1, 0)));
		if (use_sost)
			press_or_release(CC_SOST, 1'b1);
		for (i = 0; i < k; i++)
			if ($urandom_range(3, 0) != 0)
				send_event(CMD_NOTE_OFF, cur_channel, notes[i],
					7'($urandom_range(127, 0)));
		if ($urandom_range(1, 0)) begin
			if ($urandom_range(3, 0) != 0)
				press_or_release(CC_SOST, 1'b0);
			if ($urandom_range(3, 0) != 0)
				press_or_release(CC_HOLD, 1'b0);
		end else begin
			if ($urandom_range(3, 0) != 0)
				press_or_release(CC_HOLD, 1'b0);
			if ($urandom_range(3, 0) != 0)
				press_or_release(CC_SOST, 1'b0);
		end
	endtask

	task automatic send_noise();
		if ($urandom_range(9, 0) == 0)
			send_event(CMD_CTRL, cur_channel,
				$urandom_range(1, 0) ? CC_ALL_OFF : 7'($urandom_range(127, 123)),
				7'($urandom_range(127, 0)));
		else
			send_event(2'($urandom_range(3, 0)), 4'($urandom_range(15, 0)),
				7'($urandom_range(127, 0)), 7'($urandom_range(127, 0)));
	endtask

	task automatic play_random(input int count);
		int target;
		target = events_sent + count;
		while (events_sent < target) begin
			if ($urandom_range(99, 0) < 75)
				play_phrase();
			else
				send_noise();
			if (events_sent >= target - count / 2 && events_sent < target - count / 2 + 6)
				wait_drained();
		end
	endtask

	task automatic test_random_traffic();
		set_config(4'd0, 1'b0, 1'b1, 8'd50);
		play_random(PHASE_EVENTS);

		wait_drained();
		send_gap_pct = 83;
		recv_stall_pct = 22;
		set_config(4'd9, 1'b1, 1'b1, 8'($urandom_range(255, 0)));
		play_random(PHASE_EVENTS);

		wait_drained();
		send_gap_pct = 0;
		recv_stall_pct = 0;
		set_config(4'($urandom_range(15, 0)), 1'($urandom_range(1, 0)),
			1'($urandom_range(1, 0)), 8'($urandom_range(255, 0)));
		play_random(PHASE_EVENTS);
	endtask

	initial begin
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_basic_events();
		test_all_groups();
		test_soft_and_replace();
		test_random_traffic();
		wait_drained();
		if (errors == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

`default_nettype wire
